/* rtl/lbds_pkg.sv */
// ----------------------------------------------------------------------------
// Line block density selector package
// Shared widths, the threshold reset value and the item type that moves
// along the chain of line cells.
// ----------------------------------------------------------------------------
package lbds_pkg;

  // Width of one stripped line length.
  localparam int unsigned LenW = 12;

  // Width of the threshold register.
  localparam int unsigned ThrW = 14;

  // Threshold value after reset.
  localparam logic [ThrW-1:0] ThrReset = 14'd172;

  // One held line: its length, the document end mark and a valid bit.
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [LenW-1:0] len;
  } lbds_item_t;

endpackage : lbds_pkg

/* rtl/lbds_cell.sv */
// ----------------------------------------------------------------------------
// Line cell
// One stage of the line chain. It holds one line item and takes the item of
// its neighbour whenever the chain advances.
// ----------------------------------------------------------------------------
module lbds_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  lbds_pkg::lbds_item_t d_i,
  output lbds_pkg::lbds_item_t q_o
);
  import lbds_pkg::*;

  logic            valid_q;
  logic            last_q;
  logic [LenW-1:0] len_q;

  // The valid bit is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= d_i.valid;
    end
  end

  // The payload only matters while the valid bit is set.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      last_q <= d_i.last;
      len_q  <= d_i.len;
    end
  end

  assign q_o = '{valid: valid_q, last: last_q, len: len_q};

endmodule : lbds_cell

/* rtl/lbds_decide.sv */
// ----------------------------------------------------------------------------
// Segment decision
// Looks at the window of lines in front of the head line, forms the block
// sum and the block occupancy flags, and decides whether the head line is
// included and whether it opens a segment. Holds the segment state.
// ----------------------------------------------------------------------------
module lbds_decide #(
  parameter int unsigned WINDOW    = 3,
  parameter int unsigned LOOKAHEAD = 3,
  localparam int unsigned Depth    = LOOKAHEAD + WINDOW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       decide_i,
  input  lbds_pkg::lbds_item_t       window_i [Depth],
  input  logic [lbds_pkg::ThrW-1:0]  threshold_i,
  output logic                       include_o,
  output logic                       start_o
);
  import lbds_pkg::*;

  localparam int unsigned SumW = LenW + $clog2(WINDOW);
  localparam int unsigned CmpW = (SumW > ThrW) ? SumW : ThrW;

  logic [Depth-1:0]     line_nz;
  logic [Depth-1:0]     line_valid;
  logic [LOOKAHEAD:0]   blk_nz;
  logic [SumW-1:0]      sum0;
  logic                 doc_final;
  logic                 last_block;
  logic                 surge;
  logic                 in_seg_q, in_seg_d;
  logic                 prev_nz_q, prev_nz_d;

  // Per-line flags: held, nonblank, and whether the document end is in view.
  always_comb begin
    doc_final = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      line_valid[i] = window_i[i].valid;
      line_nz[i]    = window_i[i].valid && (window_i[i].len != '0);
      doc_final     = doc_final | (window_i[i].valid & window_i[i].last);
    end
  end

  // A block is nonzero when it is complete and holds a nonblank line.
  always_comb begin
    for (int k = 0; k <= LOOKAHEAD; k++) begin
      blk_nz[k] = line_valid[k+WINDOW-1] && (|line_nz[k +: WINDOW]);
    end
  end

  // Sum of the block that starts at the head line.
  always_comb begin
    sum0 = '0;
    for (int i = 0; i < WINDOW; i++) begin
      sum0 = sum0 + SumW'(window_i[i].len);
    end
  end

  // The last complete block of the document starts at the head line.
  assign last_block = doc_final && line_valid[WINDOW-1] && !line_valid[WINDOW];

  // A surge needs a full head block above threshold and busy blocks after it.
  assign surge = line_valid[WINDOW-1] &&
                 (CmpW'(sum0) > CmpW'(threshold_i)) &&
                 (&blk_nz[LOOKAHEAD:1]);

  // Decision for the head line and the next segment state.
  always_comb begin
    include_o = 1'b0;
    start_o   = 1'b0;
    in_seg_d  = in_seg_q;
    prev_nz_d = prev_nz_q;
    if (!line_valid[WINDOW-1]) begin
      in_seg_d = 1'b0;
    end else if (in_seg_q) begin
      include_o = line_nz[0] || prev_nz_q;
      prev_nz_d = line_nz[0];
      if ((!blk_nz[0] && !blk_nz[1]) || last_block) begin
        in_seg_d = 1'b0;
      end
    end else if (surge) begin
      start_o   = 1'b1;
      include_o = line_nz[0];
      prev_nz_d = line_nz[0];
      in_seg_d  = !last_block;
    end
    // The end of a document returns the segment state to its reset value.
    if (window_i[0].last) begin
      in_seg_d  = 1'b0;
      prev_nz_d = 1'b0;
    end
  end

  // Segment state moves only when a head line is decided.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_seg_q  <= 1'b0;
      prev_nz_q <= 1'b0;
    end else if (decide_i) begin
      in_seg_q  <= in_seg_d;
      prev_nz_q <= prev_nz_d;
    end
  end

endmodule : lbds_decide

/* rtl/line_block_density_selector_unit.sv */
// ----------------------------------------------------------------------------
// Line block density selector
// Marks the content lines of a document from stripped line lengths. Lines
// pass along a chain of cells; the head line is decided from the block sums
// and block occupancy of the lines behind it.
// ----------------------------------------------------------------------------
// Throughput: one line item per cycle while results are taken and no drain runs.
// Latency: a line's result is presented in the cycle after the item that comes
// LOOKAHEAD+WINDOW-1 lines later is taken, or a bubble in a drain, set by the
// length of the cell chain. After a final line the chain drains on bubbles
// until that line is out, whatever the number of held lines, and takes no item.
// Reset empties the chain, clears the segment state and sets the threshold to 172.
module line_block_density_selector_unit #(
  parameter int unsigned WINDOW    = 3,
  parameter int unsigned LOOKAHEAD = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write channel.
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lbds_pkg::ThrW-1:0] cfg_surge_threshold_i,
  // Line input channel.
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lbds_pkg::LenW-1:0] line_length_i,
  input  logic                      last_line_i,
  // Result output channel.
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      include_line_o,
  output logic                      segment_start_o,
  output logic                      last_result_o
);
  import lbds_pkg::*;

  localparam int unsigned Depth = LOOKAHEAD + WINDOW;

  lbds_item_t       window [Depth];
  logic [Depth-2:0] cell_valid;
  logic [Depth-2:0] cell_last;
  logic             draining;
  logic             can_load;
  logic             in_fire;
  logic             advance;
  logic             decide;
  logic             dec_include;
  logic             dec_start;
  logic [ThrW-1:0]  thr_q;
  logic             out_valid_q;
  logic             include_q;
  logic             start_q;
  logic             last_q;

  // Threshold register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_surge_threshold_i;
    end
  end

  // Chain control: advance on a new item, or on a bubble while draining.
  assign draining   = |(cell_valid & cell_last);
  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = can_load && !draining;
  assign in_fire    = in_valid_i && in_ready_o;
  assign advance    = in_fire || (draining && can_load);
  assign decide     = advance && window[0].valid;

  // The incoming item sits at the tail of the window.
  assign window[Depth-1] = '{valid: in_fire, last: last_line_i, len: line_length_i};

  // Chain of line cells, each fed by its neighbour towards the tail.
  for (genvar i = 0; i < Depth - 1; i++) begin : g_cell
    lbds_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (advance),
      .d_i     (window[i+1]),
      .q_o     (window[i])
    );
    assign cell_valid[i] = window[i].valid;
    assign cell_last[i]  = window[i].last;
  end

  // Decision for the head line.
  lbds_decide #(
    .WINDOW    (WINDOW),
    .LOOKAHEAD (LOOKAHEAD)
  ) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .decide_i    (decide),
    .window_i    (window),
    .threshold_i (thr_q),
    .include_o   (dec_include),
    .start_o     (dec_start)
  );

  // Output register holding one result item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (decide) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (decide) begin
      include_q <= dec_include;
      start_q   <= dec_start;
      last_q    <= window[0].last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign include_line_o  = include_q;
  assign segment_start_o = start_q;
  assign last_result_o   = last_q;

  // No item is taken while a final line is still held in the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining |-> !in_ready_o)
    else $error("item accepted while the chain drains");

  // An accepted final line always starts a drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_line_i) |=> draining)
    else $error("final line did not start a drain");

  // Outside a drain a held head line means the whole chain is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid[0] && !draining) |-> (&cell_valid))
    else $error("gap in the line chain");

endmodule : line_block_density_selector_unit

/* tb/lbds_result_checker.sv */
// ----------------------------------------------------------------------------
// Line block density selector result checker
// Watches the threshold write, line input and result channels of the unit.
// It keeps its own copy of the line window and the segment state, predicts
// the include, start and document end flags of every line, and compares
// each result taken from the unit with the oldest prediction.
// ----------------------------------------------------------------------------
module lbds_result_checker #(
  parameter int unsigned WINDOW    = 3,
  parameter int unsigned LOOKAHEAD = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [lbds_pkg::ThrW-1:0] cfg_surge_threshold_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [lbds_pkg::LenW-1:0] line_length_i,
  input  logic                      last_line_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      include_line_i,
  input  logic                      segment_start_i,
  input  logic                      last_result_i,
  output int unsigned               pending_o,
  output int unsigned               results_o,
  output int unsigned               fail_count_o
);

  import lbds_pkg::*;

  // Lines held before the head line can be decided.
  localparam int unsigned Depth = WINDOW + LOOKAHEAD;

  // Predicted flags of one line.
  typedef struct packed {
    logic keep;
    logic opens;
    logic doc_end;
  } line_verdict_t;

  logic [LenW-1:0] held_len [Depth];
  int unsigned     held_cnt;
  logic            seg_open;
  logic            prev_nonblank;
  logic [ThrW-1:0] surge_thr;
  line_verdict_t   line_verdict_q [$];
  int unsigned     mismatches = 0;
  int unsigned     checked = 0;

  // Forget the current document; the threshold is kept.
  function automatic void clear_document();
    for (int unsigned i = 0; i < Depth; i++) held_len[i] = '0;
    held_cnt      = 0;
    seg_open      = 1'b0;
    prev_nonblank = 1'b0;
  endfunction

  // Sum of the block k lines after base; blocks that run past the known
  // lines read as zero.
  function automatic int unsigned block_sum(int unsigned base, int unsigned avail,
                                            int unsigned k);
    int unsigned acc;
    acc = 0;
    if (k + WINDOW > avail) return 0;
    for (int unsigned i = 0; i < WINDOW; i++) acc += held_len[base + k + i];
    return acc;
  endfunction

  // Decide the line at base, with avail lines known from base onwards.
  function automatic line_verdict_t judge_line(int unsigned base, int unsigned avail,
                                               logic at_end);
    line_verdict_t   v;
    logic [LenW-1:0] len;
    logic            surge;
    logic            tail_block;
    v   = '0;
    len = held_len[base];
    if (avail < WINDOW) begin
      // Trailing lines start no full window and close the segment.
      seg_open = 1'b0;
    end else begin
      tail_block = at_end && (avail == WINDOW);
      if (seg_open) begin
        v.keep        = (len != 0) || prev_nonblank;
        prev_nonblank = (len != 0);
        if ((block_sum(base, avail, 0) == 0 && block_sum(base, avail, 1) == 0) ||
            tail_block) begin
          seg_open = 1'b0;
        end
      end else begin
        surge = block_sum(base, avail, 0) > surge_thr;
        for (int unsigned k = 1; k <= LOOKAHEAD; k++) begin
          if (block_sum(base, avail, k) == 0) surge = 1'b0;
        end
        if (surge) begin
          // The blank memory starts afresh with the segment.
          v.opens       = 1'b1;
          v.keep        = (len != 0);
          prev_nonblank = (len != 0);
          seg_open      = !tail_block;
        end
      end
    end
    return v;
  endfunction

  // Take one line into the window and queue the flags it releases.
  task automatic take_line(input logic [LenW-1:0] len, input logic is_last);
    int unsigned   cnt;
    line_verdict_t v;
    if (held_cnt >= Depth) held_cnt = Depth - 1;
    held_len[held_cnt] = len;
    cnt = held_cnt + 1;
    if (is_last) begin
      // The final line flushes every held line.
      for (int unsigned k = 0; k < cnt; k++) begin
        v         = judge_line(k, cnt - k, 1'b1);
        v.doc_end = (k == cnt - 1);
        line_verdict_q = {line_verdict_q, v};
      end
      clear_document();
    end else if (cnt == Depth) begin
      v = judge_line(0, Depth, 1'b0);
      line_verdict_q = {line_verdict_q, v};
      for (int unsigned k = 0; k + 1 < Depth; k++) held_len[k] = held_len[k + 1];
      held_len[Depth - 1] = '0;
      held_cnt = Depth - 1;
    end else begin
      held_cnt = cnt;
    end
  endtask

  // Report one field of a result against its prediction.
  function automatic void check_field(string field, logic want, logic got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0b, got %0b", $time, field, want, got);
    end
  endfunction

  // Compare results first, then track the threshold and predict new lines.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    line_verdict_t want;
    if (!rst_ni) begin
      surge_thr = ThrReset;
      clear_document();
      line_verdict_q.delete();
      pending_o    <= 0;
      results_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (line_verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with no line pending, expected none, got %0b%0b%0b",
                   $time, include_line_i, segment_start_i, last_result_i);
        end else begin
          want = line_verdict_q.pop_front();
          check_field("include_line", want.keep, include_line_i);
          check_field("segment_start", want.opens, segment_start_i);
          check_field("last_result", want.doc_end, last_result_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) surge_thr = cfg_surge_threshold_i;
      if (in_valid_i && in_ready_i) take_line(line_length_i, last_line_i);
      pending_o    <= line_verdict_q.size();
      results_o    <= checked;
      fail_count_o <= mismatches;
    end
  end

endmodule : lbds_result_checker

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Line block density selector testbench
// Feeds documents of stripped line lengths to the unit under a series of
// threshold settings, with random gaps and stalls on both channels and one
// long output stall, and leaves all checking to the result checker.
// ----------------------------------------------------------------------------
module tb_top;

  import lbds_pkg::*;

  localparam int unsigned Window     = 3;
  localparam int unsigned Lookahead  = 3;
  localparam int unsigned Drain      = Window + Lookahead + 4;
  localparam int unsigned HoldAt     = 200;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned Limit      = 300000;
  localparam int unsigned PhaseLines = 100;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [ThrW-1:0] cfg_thr = '0;
  logic            in_valid = 1'b0;
  logic [LenW-1:0] line_length = '0;
  logic            last_line = 1'b0;
  logic            out_ready = 1'b0;
  logic            cfg_ready;
  logic            in_ready;
  logic            out_valid;
  logic            include_line;
  logic            segment_start;
  logic            last_result;
  int unsigned     pending;
  int unsigned     results;
  int unsigned     fail_count;
  int unsigned     cycles = 0;
  int unsigned     lines_sent = 0;
  int unsigned     docs_sent = 0;

  always #5 clk = ~clk;

  line_block_density_selector_unit #(
    .WINDOW   (Window),
    .LOOKAHEAD(Lookahead)
  ) u_top (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_surge_threshold_i(cfg_thr),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .line_length_i        (line_length),
    .last_line_i          (last_line),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .include_line_o       (include_line),
    .segment_start_o      (segment_start),
    .last_result_o        (last_result)
  );

  lbds_result_checker #(
    .WINDOW   (Window),
    .LOOKAHEAD(Lookahead)
  ) u_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_i          (cfg_ready),
    .cfg_surge_threshold_i(cfg_thr),
    .in_valid_i           (in_valid),
    .in_ready_i           (in_ready),
    .line_length_i        (line_length),
    .last_line_i          (last_line),
    .out_valid_i          (out_valid),
    .out_ready_i          (out_ready),
    .include_line_i       (include_line),
    .segment_start_i      (segment_start),
    .last_result_i        (last_result),
    .pending_o            (pending),
    .results_o            (results),
    .fail_count_o         (fail_count)
  );

  // Guard against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one line item after a random gap, none when eager, and wait until it is taken.
  task automatic offer_line(input logic [LenW-1:0] len, input logic is_last,
                            input bit eager);
    int unsigned gap;
    gap = eager ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    line_length <= len;
    last_line   <= is_last;
    do @(posedge clk); while (!in_ready);
    lines_sent++;
    if (is_last) docs_sent++;
  endtask

  // One document of text-like runs of lines and sparse noise between them.
  task automatic offer_document(input int unsigned n_lines);
    bit              eager;
    bit              in_run;
    int unsigned     pick;
    logic [LenW-1:0] len;
    eager  = ($urandom_range(0, 3) == 0);
    in_run = ($urandom_range(0, 1) == 1);
    for (int unsigned k = 0; k < n_lines; k++) begin
      if ($urandom_range(0, 5) == 0) in_run = !in_run;
      pick = $urandom_range(0, 19);
      if (in_run) begin
        if (pick < 2)       len = '0;
        else if (pick == 2) len = '1;
        else if (pick == 3) len = LenW'($urandom_range(0, 4095));
        else                len = LenW'($urandom_range(1, 200));
      end else begin
        if (pick < 14) len = '0;
        else           len = LenW'($urandom_range(1, 30));
      end
      offer_line(len, k == n_lines - 1, eager);
    end
  endtask

  // Let every predicted result arrive and the flush finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  // Random documents until the phase has seen its share of lines.
  task automatic run_phase(input int unsigned quota);
    int unsigned first;
    first = lines_sent;
    while (lines_sent - first < quota) begin
      if ($urandom_range(0, 2) == 0) offer_document($urandom_range(1, 7));
      else                           offer_document($urandom_range(8, 40));
    end
    settle();
  endtask

  // Write the threshold while the unit is idle.
  task automatic write_threshold(input logic [ThrW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_thr   <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Output side: random stalls, calm stretches and one long hold-off.
  initial begin : drain_results
    int unsigned stall;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, 4);
      if (taken == HoldAt) stall = HoldCycles;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  // Reset, directed documents, then random phases under several thresholds.
  initial begin : stimulus
    logic [LenW-1:0] sweep [24];
    sweep = '{
      12'd4095,
      12'd100, 12'd0, 12'd200, 12'd300, 12'd0, 12'd0, 12'd0,
      12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd50, 12'd60,
      12'd72, 12'd50, 12'd50, 12'd72, 12'd50, 12'd51, 12'd60, 12'd60, 12'd0
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A one-line document, a segment with blank lines inside and around it,
    // and blocks sitting exactly on the reset threshold.
    for (int unsigned k = 0; k < 24; k++) begin
      offer_line(sweep[k], k == 0 || k == 14 || k == 23, 1'b0);
    end
    settle();

    run_phase(PhaseLines);
    write_threshold('0);
    run_phase(PhaseLines);
    write_threshold('1);
    run_phase(PhaseLines);
    write_threshold(ThrW'($urandom_range(0, 16383)));
    run_phase(PhaseLines);
    write_threshold(ThrW'($urandom_range(1, 400)));
    run_phase(PhaseLines);

    $display("Covered %0d lines in %0d documents under five threshold settings, %0d results.",
             lines_sent, docs_sent, results);
    $display("The output side stalled for %0d cycles once to back up the line input.",
             HoldCycles);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : tb_top
